>>> src/aelr_pkg.sv
// Shared types, constants and the log table for the approximate entropy block.
package aelr_pkg;

  localparam int MAX_RETURNS_DEF = 256;
  localparam int QDEPTH          = 2;

  localparam logic [2:0]  EMBED_DIM_RST  = 3'd2;
  localparam logic [15:0] TOL_FACTOR_RST = 16'd13107;
  localparam logic [7:0]  MIN_RET_RST    = 8'd5;

  typedef enum logic [1:0] {
    CFG_EMBED_DIM  = 2'd0,
    CFG_TOL_FACTOR = 2'd1,
    CFG_MIN_RET    = 2'd2
  } cfg_idx_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZTOL = 2'd2;

  typedef struct packed {
    logic [2:0]  embed_dim;
    logic [15:0] tol_factor;
    logic [7:0]  min_ret;
  } cfg_t;

  // one queue entry: an optional return plus an end-of-series mark
  typedef struct packed {
    logic        ret;
    logic        fin;
    logic [31:0] val;
  } cmd_t;

  typedef logic [64:0][31:0] ln_tab_t;

  // shift-subtract division, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/64) in Q8.24 from the odd atanh series in Q0.32
  function automatic ln_tab_t ln_tab_build();
    ln_tab_t     t;
    logic [63:0] z, z2, term, sum;
    for (int i = 0; i <= 64; i++) begin
      z    = udiv64(64'(i) << 32, 64'(128 + i));
      z2   = (z * z) >> 32;
      term = z;
      sum  = '0;
      for (int k = 1; k <= 31; k += 2) begin
        sum  = sum + udiv64(term, 64'(k));
        term = (term * z2) >> 32;
      end
      t[i] = 32'((sum << 1) >> 8);
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = ln_tab_build();

endpackage

>>> src/aelr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aelr_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/aelr_fifo.sv
// Small command queue between the front and the back.
module aelr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  aelr_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output aelr_pkg::cmd_t dout,
  output logic          empty
);
  import aelr_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  cmd_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> src/aelr_ln.sv
// Multi-cycle natural log, Q16.16 in, Q8.24 out: normalize, table lookup, interpolate.
module aelr_ln (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        v,
  output logic               done,
  output logic signed [31:0] res
);
  import aelr_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_MUL  = 4'b0100,
    L_SUM  = 4'b1000
  } lst_t;

  lst_t               st_r;
  logic [31:0]        m_r;
  logic [4:0]         p_r;
  logic [2:0]         stp_r;
  logic               zero_r;
  logic [31:0]        base_r;
  logic [56:0]        prod_r;
  logic signed [31:0] pt_r;
  logic signed [31:0] res_r;
  logic               done_r;

  logic [4:0]         sh;
  logic               top_zero;
  logic [6:0]         idx;
  logic [31:0]        diff;
  logic signed [6:0]  pe;

  always_comb begin
    sh       = 5'd16 >> stp_r;
    top_zero = ((m_r >> (6'd32 - {1'b0, sh})) == 32'd0);
    idx      = {1'b0, m_r[30:25]};
    diff     = LN_TAB[idx + 7'd1] - LN_TAB[idx];
    pe       = $signed({2'b00, p_r}) - 7'sd16;
  end

  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            m_r    <= v;
            p_r    <= 5'd31;
            stp_r  <= '0;
            zero_r <= (v == 32'd0);
            st_r   <= L_NORM;
          end
        end
        L_NORM: begin
          if (top_zero) begin
            m_r <= m_r << sh;
            p_r <= p_r - sh;
          end
          stp_r <= stp_r + 1'b1;
          if (stp_r == 3'd4) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          base_r <= LN_TAB[idx];
          prod_r <= 57'(diff) * 57'(m_r[24:0]);
          pt_r   <= 32'(pe * $signed({1'b0, LN_TAB[64]}));
          st_r   <= L_SUM;
        end
        L_SUM: begin
          res_r  <= zero_r ? 32'sd0 : pt_r + $signed(base_r) + $signed(prod_r[56:25]);
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end
endmodule

>>> src/aelr_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module aelr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] n_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] rem_sh;
  logic        qbit;

  always_comb begin
    rem_sh = {rem_r[31:0], n_r[63]};
    qbit   = (rem_sh >= {1'b0, den_r});
  end

  assign done = done_r;
  assign quo  = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= qbit ? rem_sh - {1'b0, den_r} : rem_sh;
        n_r   <= {n_r[62:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/aelr_front.sv
// Front: takes prices, works out absolute log returns, queues returns and end marks.
module aelr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    in_price,
  input  logic           in_last,
  input  logic           in_push,
  output logic           in_full,
  output logic           q_push,
  output aelr_pkg::cmd_t q_entry,
  input  logic           q_full
);
  import aelr_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LN   = 3'b010,
    F_PUSH = 3'b100
  } fst_t;

  fst_t               st_r;
  logic               last_r;
  logic signed [31:0] prev_ln_r;
  logic               prev_ok_r;
  cmd_t               ent_r;

  logic               ln_go, ln_done;
  logic signed [31:0] ln_res;
  logic signed [31:0] d;

  assign in_full = (st_r != F_IDLE);
  assign ln_go   = (st_r == F_IDLE) && in_push && (in_price != 32'd0);
  assign q_push  = (st_r == F_PUSH) && !q_full;
  assign q_entry = ent_r;
  assign d       = ln_res - prev_ln_r;

  aelr_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_go),
    .v     (in_price),
    .done  (ln_done),
    .res   (ln_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_IDLE;
      prev_ok_r <= 1'b0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (in_push) begin
            last_r <= in_last;
            if (in_price == 32'd0) begin
              prev_ok_r <= 1'b0;
              if (in_last) begin
                ent_r <= '{ret: 1'b0, fin: 1'b1, val: 32'd0};
                st_r  <= F_PUSH;
              end
            end else begin
              st_r <= F_LN;
            end
          end
        end
        F_LN: begin
          if (ln_done) begin
            ent_r     <= '{ret: prev_ok_r, fin: last_r, val: d[31] ? -d : d};
            prev_ln_r <= ln_res;
            prev_ok_r <= !last_r;
            st_r      <= (prev_ok_r || last_r) ? F_PUSH : F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end
endmodule

>>> src/aelr_back.sv
// Back: stores returns, then on the end mark runs statistics and template matching.
module aelr_back #(
  parameter int MAX_RETURNS = aelr_pkg::MAX_RETURNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aelr_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  aelr_pkg::cfg_t     cfg,
  output logic signed [31:0] out_entropy,
  output logic [1:0]         out_status,
  output logic               out_empty,
  input  logic               out_pop
);
  import aelr_pkg::*;

  localparam int AW = $clog2(MAX_RETURNS);
  localparam int CW = $clog2(MAX_RETURNS + 1);

  typedef enum logic [16:0] {
    B_IDLE  = 17'h00001,
    B_CHECK = 17'h00002,
    B_SUM   = 17'h00004,
    B_MEAN  = 17'h00008,
    B_VAR   = 17'h00010,
    B_VDIV  = 17'h00020,
    B_SQRT  = 17'h00040,
    B_TOL   = 17'h00080,
    B_TCHK  = 17'h00100,
    B_PAIR  = 17'h00200,
    B_LNS   = 17'h00400,
    B_LNC   = 17'h00800,
    B_PDS   = 17'h01000,
    B_PDIV  = 17'h02000,
    B_PLS   = 17'h04000,
    B_PLN   = 17'h08000,
    B_OUT   = 17'h10000
  } bst_t;

  bst_t               st_r;
  logic [CW-1:0]      cnt_r, idx_r, j_r, match_r;
  logic [2:0]         k_r;
  logic               vld_r, vld2_r, pass_r;
  logic [63:0]        acc_r, sq_r, x_r, res_r, bit_r;
  logic [31:0]        mean_r, tol_r, dmax_r;
  logic signed [63:0] phi0_r;
  logic signed [31:0] entropy_r;
  logic [1:0]         status_r;
  logic               ovld_r;

  logic [2:0]         m_eff, mm;
  logic [CW-1:0]      ntmp, a_full, b_full;
  logic [31:0]        ra, rb, absdiff, dmean;
  logic               issuing, we, pair_end;
  logic [63:0]        sqrt_sum;
  logic               div_go, div_done, ln_go, ln_done;
  logic [63:0]        div_quo;
  logic [31:0]        ln_v;
  logic signed [31:0] ln_res;
  logic signed [63:0] phi_v;

  always_comb begin
    if (cfg.embed_dim == 3'd0) begin
      m_eff = 3'd1;
    end else if (cfg.embed_dim > 3'd4) begin
      m_eff = 3'd4;
    end else begin
      m_eff = cfg.embed_dim;
    end
    mm       = m_eff + {2'b00, pass_r};
    ntmp     = cnt_r - CW'(mm) + CW'(1);
    a_full   = idx_r + CW'(k_r);
    b_full   = j_r + CW'(k_r);
    absdiff  = (ra > rb) ? ra - rb : rb - ra;
    dmean    = (ra > mean_r) ? ra - mean_r : mean_r - ra;
    issuing  = (k_r < mm);
    pair_end = !issuing && !vld_r;
    sqrt_sum = res_r + bit_r;
    phi_v    = $signed(div_quo) - {{32{ln_res[31]}}, ln_res};
    cmd_pop  = (st_r == B_IDLE) && cmd_valid;
    we       = cmd_pop && cmd.ret && (cnt_r < CW'(MAX_RETURNS));
    div_go   = ((st_r == B_SUM) && (idx_r == cnt_r) && !vld_r)
            || ((st_r == B_VAR) && (idx_r == cnt_r) && !vld_r && !vld2_r)
            || (st_r == B_PDS);
    ln_go    = (st_r == B_LNS) || (st_r == B_PLS);
    ln_v     = (st_r == B_LNS) ? (32'(match_r) << 16) : (32'(ntmp) << 16);
  end

  aelr_ram #(.W(32), .DEPTH(MAX_RETURNS)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (cmd.val),
    .raddr (a_full[AW-1:0]),
    .rdata (ra)
  );

  aelr_ram #(.W(32), .DEPTH(MAX_RETURNS)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (cmd.val),
    .raddr (b_full[AW-1:0]),
    .rdata (rb)
  );

  aelr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (acc_r),
    .den   ((st_r == B_PDS) ? 32'(ntmp) : 32'(cnt_r)),
    .done  (div_done),
    .quo   (div_quo)
  );

  aelr_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_go),
    .v     (ln_v),
    .done  (ln_done),
    .res   (ln_res)
  );

  assign out_entropy = entropy_r;
  assign out_status  = status_r;
  assign out_empty   = !ovld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (out_pop && ovld_r) begin
        ovld_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (cmd_pop) begin
            if (we) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (cmd.fin) begin
              st_r <= B_CHECK;
            end
          end
        end
        B_CHECK: begin
          // the previous result has to leave before this series overwrites it
          if (!ovld_r) begin
            idx_r  <= '0;
            k_r    <= '0;
            acc_r  <= '0;
            vld_r  <= 1'b0;
            vld2_r <= 1'b0;
            pass_r <= 1'b0;
            if ((16'(cnt_r) <= 16'(cfg.min_ret)) || (16'(cnt_r) <= 16'(m_eff) + 16'd1)) begin
              status_r  <= ST_FEW;
              entropy_r <= '0;
              st_r      <= B_OUT;
            end else begin
              st_r <= B_SUM;
            end
          end
        end
        B_SUM: begin
          vld_r <= (idx_r != cnt_r);
          if (idx_r != cnt_r) begin
            idx_r <= idx_r + 1'b1;
          end
          if (vld_r) begin
            acc_r <= acc_r + 64'(ra);
          end
          if (div_go) begin
            st_r <= B_MEAN;
          end
        end
        B_MEAN: begin
          if (div_done) begin
            mean_r <= div_quo[31:0];
            idx_r  <= '0;
            acc_r  <= '0;
            vld_r  <= 1'b0;
            vld2_r <= 1'b0;
            st_r   <= B_VAR;
          end
        end
        B_VAR: begin
          vld_r  <= (idx_r != cnt_r);
          vld2_r <= vld_r;
          if (idx_r != cnt_r) begin
            idx_r <= idx_r + 1'b1;
          end
          if (vld_r) begin
            sq_r <= 64'(dmean) * 64'(dmean);
          end
          if (vld2_r) begin
            acc_r <= acc_r + (sq_r >> 8);
          end
          if (div_go) begin
            st_r <= B_VDIV;
          end
        end
        B_VDIV: begin
          if (div_done) begin
            x_r   <= div_quo << 8;
            res_r <= '0;
            bit_r <= 64'd1 << 62;
            st_r  <= B_SQRT;
          end
        end
        B_SQRT: begin
          // one result bit per cycle, two radicand bits at a time
          if (bit_r == 64'd0) begin
            st_r <= B_TOL;
          end else begin
            if (x_r >= sqrt_sum) begin
              x_r   <= x_r - sqrt_sum;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        B_TOL: begin
          tol_r <= 32'((49'(cfg.tol_factor) * 49'(res_r[32:0])) >> 16);
          st_r  <= B_TCHK;
        end
        B_TCHK: begin
          if (tol_r == 32'd0) begin
            status_r  <= ST_ZTOL;
            entropy_r <= '0;
            st_r      <= B_OUT;
          end else begin
            idx_r   <= '0;
            j_r     <= '0;
            k_r     <= '0;
            vld_r   <= 1'b0;
            dmax_r  <= '0;
            match_r <= '0;
            acc_r   <= '0;
            st_r    <= B_PAIR;
          end
        end
        B_PAIR: begin
          // read template element k of i and j, fold into the running max
          vld_r <= issuing;
          if (issuing) begin
            k_r <= k_r + 1'b1;
          end
          if (vld_r && (absdiff > dmax_r)) begin
            dmax_r <= absdiff;
          end
          if (pair_end) begin
            if (dmax_r <= tol_r) begin
              match_r <= match_r + 1'b1;
            end
            dmax_r <= '0;
            k_r    <= '0;
            if (j_r == ntmp - 1'b1) begin
              j_r  <= '0;
              st_r <= B_LNS;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        B_LNS: begin
          st_r <= B_LNC;
        end
        B_LNC: begin
          if (ln_done) begin
            acc_r   <= acc_r + {32'd0, ln_res};
            match_r <= '0;
            if (idx_r == ntmp - 1'b1) begin
              st_r <= B_PDS;
            end else begin
              idx_r <= idx_r + 1'b1;
              st_r  <= B_PAIR;
            end
          end
        end
        B_PDS: begin
          st_r <= B_PDIV;
        end
        B_PDIV: begin
          if (div_done) begin
            st_r <= B_PLS;
          end
        end
        B_PLS: begin
          st_r <= B_PLN;
        end
        B_PLN: begin
          if (ln_done) begin
            if (!pass_r) begin
              phi0_r  <= phi_v;
              pass_r  <= 1'b1;
              idx_r   <= '0;
              j_r     <= '0;
              k_r     <= '0;
              vld_r   <= 1'b0;
              dmax_r  <= '0;
              match_r <= '0;
              acc_r   <= '0;
              st_r    <= B_PAIR;
            end else begin
              entropy_r <= 32'(phi0_r - phi_v);
              status_r  <= ST_OK;
              st_r      <= B_OUT;
            end
          end
        end
        B_OUT: begin
          if (!ovld_r) begin
            ovld_r <= 1'b1;
            cnt_r  <= '0;
            st_r   <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

>>> src/approx_entropy_abs_log_returns.sv
// Top level: config registers, front, command queue and back of the entropy block.
//
// Prices enter as Q16.16 on in_price with in_last marking the end of a series;
// a beat is taken when in_push is high and in_full is low. In the front a nonzero
// price goes through 5-step leading-one normalization and table lookup with
// interpolation, then a queue push if it yields a return or end mark; a zero
// price queues an end mark only if it ends the series. Returns land in the RAM.
// One result per series appears on out_entropy / out_status while out_empty
// is low and leaves on out_pop. After the last price of N returns, the back
// runs two passes over the RAM with a divide each (mean, variance), a square
// root, then for template length k in {m, m+1} with T = N-k+1 matches all T*T
// template pairs, one compare per cycle on the RAM ports while a pair is read.
// A result waiting on a stalled receiver holds the back at the end of the next
// series; the front keeps taking prices until the two-entry queue fills.
// Reset (synchronous, rst_n low) empties the queue, drops stored returns and
// loads embed_dim 2, tolerance_factor 13107, min_returns 5. The cfg port
// writes register cfg_index with cfg_wdata when cfg_we is high.
module approx_entropy_abs_log_returns #(
  parameter int MAX_RETURNS = aelr_pkg::MAX_RETURNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_price,
  input  logic               in_last,
  input  logic               in_push,
  output logic               in_full,
  output logic signed [31:0] out_entropy,
  output logic [1:0]         out_status,
  output logic               out_empty,
  input  logic               out_pop,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import aelr_pkg::*;

  cfg_t cfg_r;
  cmd_t q_in, q_out;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{embed_dim: EMBED_DIM_RST, tol_factor: TOL_FACTOR_RST, min_ret: MIN_RET_RST};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EMBED_DIM:  cfg_r.embed_dim  <= cfg_wdata[2:0];
        CFG_TOL_FACTOR: cfg_r.tol_factor <= cfg_wdata;
        CFG_MIN_RET:    cfg_r.min_ret    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  aelr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_price (in_price),
    .in_last  (in_last),
    .in_push  (in_push),
    .in_full  (in_full),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full)
  );

  aelr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  aelr_back #(.MAX_RETURNS(MAX_RETURNS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (q_out),
    .cmd_valid   (!q_empty),
    .cmd_pop     (q_pop),
    .cfg         (cfg_r),
    .out_entropy (out_entropy),
    .out_status  (out_status),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );
endmodule

>>> tb/tb.sv
// Self-checking testbench for the approximate entropy of absolute log returns block.
`timescale 1ns / 1ps

import aelr_pkg::*;

class entropy_scoreboard;
  logic [31:0] ln_lut [0:64];
  logic [2:0]  embed_dim;
  logic [15:0] tol_factor;
  logic [7:0]  min_ret;
  logic [31:0] prev_price;
  bit          have_prev;
  logic [31:0] rets [0:255];
  int          n_rets;
  logic [31:0] exp_entropy [$];
  logic [1:0]  exp_status [$];
  int          errors;
  int          n_results;
  int          n_by_status [3];

  function new();
    longint unsigned z, z2, term, acc;
    for (int i = 0; i <= 64; i++) begin
      z = (64'(i) << 32) / 64'(128 + i);
      z2 = (z * z) >> 32;
      term = z;
      acc = 0;
      for (int k = 1; k <= 31; k += 2) begin
        acc += term / 64'(k);
        term = (term * z2) >> 32;
      end
      ln_lut[i] = 32'((2 * acc) >> 8);
    end
    reset_state();
    embed_dim = EMBED_DIM_RST;
    tol_factor = TOL_FACTOR_RST;
    min_ret = MIN_RET_RST;
  endfunction

  function void reset_state();
    prev_price = '0;
    have_prev = 0;
    n_rets = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [15:0] val);
    case (idx)
      CFG_EMBED_DIM:  embed_dim = val[2:0];
      CFG_TOL_FACTOR: tol_factor = val;
      CFG_MIN_RET:    min_ret = val[7:0];
      default: ;
    endcase
  endfunction

  function longint ln_fx(logic [31:0] v);
    int p;
    logic [31:0] mant, diff;
    if (v == 0) return 0;
    p = 31;
    while (!v[p]) p--;
    mant = v << (31 - p);
    diff = ln_lut[mant[30:25] + 1] - ln_lut[mant[30:25]];
    return longint'(p - 16) * longint'(ln_lut[64]) + longint'(ln_lut[mant[30:25]])
         + longint'((64'(diff) * 64'(mant[24:0])) >> 25);
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function longint phi(int n, int k, logic [31:0] tol);
    int cnt, hits;
    logic [31:0] d, a, b, df;
    longint unsigned acc;
    cnt = n - k + 1;
    acc = 0;
    for (int i = 0; i < cnt; i++) begin
      hits = 0;
      for (int j = 0; j < cnt; j++) begin
        d = 0;
        for (int t = 0; t < k; t++) begin
          a = rets[i + t];
          b = rets[j + t];
          df = a > b ? a - b : b - a;
          if (df > d) d = df;
        end
        if (d <= tol) hits++;
      end
      acc += longint'(ln_fx(32'(hits) << 16));
    end
    return longint'(acc / 64'(cnt)) - ln_fx(32'(cnt) << 16);
  endfunction

  // one accepted input beat
  function void note_price(logic [31:0] price, logic last);
    longint d, ent;
    int m;
    logic [1:0] st;
    longint unsigned acc, var_acc, sd, tol, dd;
    logic [31:0] mean;
    if (have_prev && prev_price != 0 && price != 0) begin
      d = ln_fx(price) - ln_fx(prev_price);
      if (d < 0) d = -d;
      if (n_rets < 256) begin
        rets[n_rets] = 32'(d);
        n_rets++;
      end
    end
    prev_price = price;
    have_prev = 1;
    if (!last) return;
    ent = 0;
    st = ST_OK;
    m = embed_dim < 1 ? 1 : (embed_dim > 4 ? 4 : int'(embed_dim));
    if (n_rets <= int'(min_ret) || n_rets <= m + 1) begin
      st = ST_FEW;
    end else begin
      acc = 0;
      for (int i = 0; i < n_rets; i++) acc += rets[i];
      mean = 32'(acc / 64'(n_rets));
      var_acc = 0;
      for (int i = 0; i < n_rets; i++) begin
        dd = rets[i] > mean ? rets[i] - mean : mean - rets[i];
        var_acc += (dd * dd) >> 8;
      end
      var_acc /= 64'(n_rets);
      sd = int_sqrt(var_acc << 8);
      tol = (64'(tol_factor) * sd) >> 16;
      if (tol == 0) st = ST_ZTOL;
      else ent = phi(n_rets, m, 32'(tol)) - phi(n_rets, m + 1, 32'(tol));
    end
    exp_entropy = {exp_entropy, 32'(ent)};
    exp_status = {exp_status, st};
    reset_state();
  endfunction

  function void check_result(logic [31:0] ent, logic [1:0] st);
    logic [31:0] e_ent;
    logic [1:0] e_st;
    if (exp_status.size() == 0) begin
      $error("result beat with nothing expected: entropy %h status %0d", ent, st);
      errors++;
      return;
    end
    e_ent = exp_entropy.pop_front();
    e_st = exp_status.pop_front();
    n_results++;
    if (e_st <= ST_ZTOL) n_by_status[e_st]++;
    if (st !== e_st) begin
      $error("status: expected %0d, got %0d", e_st, st);
      errors++;
    end
    if (ent !== e_ent) begin
      $error("entropy: expected %h, got %h", e_ent, ent);
      errors++;
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module tb;
  logic               clk;
  logic               rst_n;
  logic [31:0]        in_price;
  logic               in_last;
  logic               in_push;
  logic               in_full;
  logic signed [31:0] out_entropy;
  logic [1:0]         out_status;
  logic               out_empty;
  logic               out_pop;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  entropy_scoreboard sb;
  bit  hold_req;
  int  idle_cycles;
  int  n_prices;
  int  n_cfg_writes;

  approx_entropy_abs_log_returns u_top (
    .clk(clk), .rst_n(rst_n),
    .in_price(in_price), .in_last(in_last), .in_push(in_push), .in_full(in_full),
    .out_entropy(out_entropy), .out_status(out_status), .out_empty(out_empty),
    .out_pop(out_pop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles without any accepted beat; covers the longest series back pass
  always @(posedge clk) begin
    if (rst_n && ((in_push && !in_full) || (out_pop && !out_empty))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_price(logic [31:0] price, logic last);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_push = 0;
    end
    @(negedge clk);
    in_push = 1;
    in_price = price;
    in_last = last;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    sb.note_price(price, last);
    n_prices++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, val);
    n_cfg_writes++;
  endtask

  task automatic set_cfg(logic [15:0] ed, logic [15:0] tf, logic [15:0] mr);
    write_cfg(CFG_EMBED_DIM, ed);
    write_cfg(CFG_TOL_FACTOR, tf);
    write_cfg(CFG_MIN_RET, mr);
  endtask

  // random-walk series; occasional zero and wild prices break it up
  task automatic send_series(int len);
    logic [31:0] p;
    int sel;
    p = $urandom();
    if (p < 32'h100) p = 32'h10000;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 31);
      if (sel == 0) push_price(32'h0, i == len - 1);
      else if (sel == 1) push_price($urandom(), i == len - 1);
      else begin
        p = p + ($urandom() >> $urandom_range(4, 12)) - ($urandom() >> $urandom_range(4, 12));
        if (p == 0) p = 1;
        push_price(p, i == len - 1);
      end
    end
  endtask

  task automatic send_list(logic [31:0] vals [$]);
    foreach (vals[i]) push_price(vals[i], i == vals.size() - 1);
  endtask

  // result side
  initial begin
    int gap;
    bit held;
    out_pop = 0;
    held = 0;
    wait (rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        @(negedge clk);
        out_pop = 0;
        repeat (3000) @(posedge clk);
      end
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        @(negedge clk);
        out_pop = 0;
      end
      @(negedge clk);
      out_pop = 1;
      forever begin
        @(posedge clk);
        if (!out_empty) break;
      end
      sb.check_result(out_entropy, out_status);
    end
  end

  initial begin
    logic [31:0] flat [$];
    sb = new();
    rst_n = 0;
    in_push = 0;
    in_price = 0;
    in_last = 0;
    cfg_we = 0;
    cfg_index = CFG_EMBED_DIM;
    cfg_wdata = 0;
    hold_req = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset config first
    push_price(32'h0001_0000, 1);                       // lone last item
    send_list('{32'h1_0000, 32'h1_2000, 32'h0_F000, 32'h1_8000, 32'h1_1000,
                32'h1_4000, 32'h0_E000, 32'h1_3000, 32'h1_0000});
    send_list('{32'h1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0, 32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h3});
    for (int i = 0; i < 8; i++) flat = {flat, 32'h0005_0000};
    send_list(flat);                                    // constant prices, zero spread
    wait_drained();

    set_cfg(0, 16'hFFFF, 0);
    send_series(7);
    send_series(3);
    wait_drained();
    set_cfg(7, 0, 255);
    send_series(10);
    wait_drained();
    set_cfg(7, 0, 0);
    send_series(10);
    wait_drained();

    // one series longer than the return store
    set_cfg(1, 13107, 5);
    send_series(262);
    wait_drained();

    // random phases across several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_cfg(EMBED_DIM_RST, TOL_FACTOR_RST, MIN_RET_RST);
        1: set_cfg(1, 65535, 0);
        2: set_cfg(4, 30000, 3);
        3: set_cfg(3, 8000, 10);
        default: set_cfg($urandom_range(0, 7), $urandom_range(1, 65535),
                         $urandom_range(0, 12));
      endcase
      if (ph == 2) begin
        hold_req = 1;
        repeat (12) send_series(4);
      end
      repeat (7) begin
        if ($urandom_range(0, 7) == 0) send_series(1);
        else send_series($urandom_range(4, 16));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d prices, %0d series results (ok %0d, few %0d, zero tol %0d),",
             n_prices, sb.n_results, sb.n_by_status[0], sb.n_by_status[1],
             sb.n_by_status[2]);
    $display("%0d config writes incl. out-of-range embed dims and a full return store.",
             n_cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
